[sv/vsvb_pkg.sv]
`default_nettype none
package vsvb_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned NUM_ROWS = 3;
  localparam int unsigned NUM_COLS = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X_COLS01 = 3'd0,
    REG_ROW_X_COLS23 = 3'd1,
    REG_ROW_Y_COLS01 = 3'd2,
    REG_ROW_Y_COLS23 = 3'd3,
    REG_ROW_Z_COLS01 = 3'd4,
    REG_ROW_Z_COLS23 = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] vertex_x;
    logic signed [DATA_W-1:0] vertex_y;
    logic signed [DATA_W-1:0] vertex_z;
    logic signed [DATA_W-1:0] vertex_w;
    logic                     first_vertex;
    logic                     last_vertex;
  } vertex_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_x;
    logic signed [DATA_W-1:0] max_x;
    logic signed [DATA_W-1:0] min_y;
    logic signed [DATA_W-1:0] max_y;
    logic signed [DATA_W-1:0] min_z;
    logic signed [DATA_W-1:0] max_z;
  } bounds_req_t;

  typedef struct packed {
    logic first;
    logic last;
  } vtx_flags_t;

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_regs_t;

  function automatic logic [CFG_W-1:0] cfg_reset_value(input logic [IDX_W-1:0] idx);
    logic [CFG_W-1:0] val;
    val = '0;
    case (idx)
      REG_ROW_X_COLS01: val = 64'h0000_0000_0001_0000;
      REG_ROW_Y_COLS01: val = 64'h0001_0000_0000_0000;
      REG_ROW_Z_COLS23: val = 64'h0000_0000_0001_0000;
      default:          val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

[sv/vsvb_cfg.sv]
`default_nettype none
module vsvb_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vsvb_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [vsvb_pkg::CFG_W-1:0]    pwdata,
  output logic      [vsvb_pkg::CFG_W-1:0]    prdata,
  output logic                               pready,
  output vsvb_pkg::cfg_regs_t                cfg_o
);
  import vsvb_pkg::*;

  cfg_regs_t       regs_q;
  logic [IDX_W-1:0] idx;
  logic            idx_ok;
  logic            wr_en;

  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign idx_ok = idx <= REG_ROW_Z_COLS23;
  assign wr_en  = psel && penable && pwrite && idx_ok;
  assign pready = 1'b1;
  assign prdata = idx_ok ? regs_q[idx] : '0;
  assign cfg_o  = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= cfg_reset_value(IDX_W'(i));
      end
    end else if (wr_en) begin
      regs_q[idx] <= pwdata;
    end
  end

endmodule
`default_nettype wire

[sv/vsvb_mult.sv]
`default_nettype none
module vsvb_mult #(
  parameter int unsigned CoordWidth = vsvb_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire vsvb_pkg::vertex_req_t in_req_i,
  input  wire vsvb_pkg::cfg_regs_t  cfg_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output vsvb_pkg::vtx_flags_t      out_flags_o,
  output logic [vsvb_pkg::NUM_ROWS-1:0][vsvb_pkg::NUM_COLS-1:0][2*CoordWidth-1:0] out_prod_o
);
  import vsvb_pkg::*;

  localparam int unsigned ProdW = 2 * CoordWidth;

  logic        vtx_vld_q;
  vertex_req_t vtx_q;
  logic        prd_vld_q;
  vtx_flags_t  prd_flags_q;
  logic [NUM_ROWS-1:0][NUM_COLS-1:0][ProdW-1:0] prod_q;
  logic [NUM_ROWS-1:0][NUM_COLS-1:0][ProdW-1:0] prod_d;
  logic signed [CoordWidth-1:0] vcoord [NUM_COLS];
  logic        prd_ready;
  logic        vtx_ready;

  assign prd_ready  = !prd_vld_q || out_ready_i;
  assign vtx_ready  = !vtx_vld_q || prd_ready;
  assign in_ready_o = vtx_ready;

  assign vcoord[0] = signed'(vtx_q.vertex_x[CoordWidth-1:0]);
  assign vcoord[1] = signed'(vtx_q.vertex_y[CoordWidth-1:0]);
  assign vcoord[2] = signed'(vtx_q.vertex_z[CoordWidth-1:0]);
  assign vcoord[3] = signed'(vtx_q.vertex_w[CoordWidth-1:0]);

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      logic [CFG_W-1:0]             word;
      logic [DATA_W-1:0]            half;
      logic signed [CoordWidth-1:0] coef;
      logic signed [ProdW-1:0]      prod;
      assign word = cfg_i[2*r + c/2];
      assign half = (c % 2 == 1) ? word[CFG_W-1:DATA_W] : word[DATA_W-1:0];
      assign coef = signed'(half[CoordWidth-1:0]);
      assign prod = coef * vcoord[c];
      assign prod_d[r][c] = prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_vld_q <= 1'b0;
      prd_vld_q <= 1'b0;
    end else begin
      if (vtx_ready) begin
        vtx_vld_q <= in_valid_i;
      end
      if (prd_ready) begin
        prd_vld_q <= vtx_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_ready && in_valid_i) begin
      vtx_q <= in_req_i;
    end
    if (prd_ready && vtx_vld_q) begin
      prod_q            <= prod_d;
      prd_flags_q.first <= vtx_q.first_vertex;
      prd_flags_q.last  <= vtx_q.last_vertex;
    end
  end

  assign out_valid_o = prd_vld_q;
  assign out_flags_o = prd_flags_q;
  assign out_prod_o  = prod_q;

endmodule
`default_nettype wire

[sv/vsvb_reduce.sv]
`default_nettype none
module vsvb_reduce #(
  parameter int unsigned CoordWidth   = vsvb_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FractionBits = vsvb_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire vsvb_pkg::vtx_flags_t in_flags_i,
  input  wire logic [vsvb_pkg::NUM_ROWS-1:0][vsvb_pkg::NUM_COLS-1:0][2*CoordWidth-1:0] in_prod_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output vsvb_pkg::vtx_flags_t      out_flags_o,
  output logic [vsvb_pkg::NUM_ROWS-1:0][CoordWidth-1:0] out_coord_o
);
  import vsvb_pkg::*;

  localparam int unsigned ProdW = 2 * CoordWidth;
  localparam int unsigned SumW  = ProdW + 2;
  localparam logic signed [SumW-1:0] SatMax =
    {{(SumW-CoordWidth+1){1'b0}}, {(CoordWidth-1){1'b1}}};
  localparam logic signed [SumW-1:0] SatMin = ~SatMax;

  logic       sum_vld_q;
  vtx_flags_t sum_flags_q;
  logic [NUM_ROWS-1:0][SumW-1:0] sum_q;
  logic [NUM_ROWS-1:0][SumW-1:0] sum_d;
  logic       crd_vld_q;
  vtx_flags_t crd_flags_q;
  logic [NUM_ROWS-1:0][CoordWidth-1:0] crd_q;
  logic [NUM_ROWS-1:0][CoordWidth-1:0] crd_d;
  logic       sum_ready;
  logic       crd_ready;

  assign crd_ready  = !crd_vld_q || out_ready_i;
  assign sum_ready  = !sum_vld_q || crd_ready;
  assign in_ready_o = sum_ready;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    logic signed [SumW-1:0] ext [NUM_COLS];
    logic signed [SumW-1:0] shifted;
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      assign ext[c] = SumW'(signed'(in_prod_i[r][c]));
    end
    assign sum_d[r] = (ext[0] + ext[1]) + (ext[2] + ext[3]);

    // floor of the exact sum, then clamp to the coordinate range
    assign shifted  = signed'(sum_q[r]) >>> FractionBits;
    assign crd_d[r] = (shifted > SatMax) ? SatMax[CoordWidth-1:0] :
                      (shifted < SatMin) ? SatMin[CoordWidth-1:0] :
                      shifted[CoordWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      crd_vld_q <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_vld_q <= in_valid_i;
      end
      if (crd_ready) begin
        crd_vld_q <= sum_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && in_valid_i) begin
      sum_q       <= sum_d;
      sum_flags_q <= in_flags_i;
    end
    if (crd_ready && sum_vld_q) begin
      crd_q       <= crd_d;
      crd_flags_q <= sum_flags_q;
    end
  end

  assign out_valid_o = crd_vld_q;
  assign out_flags_o = crd_flags_q;
  assign out_coord_o = crd_q;

endmodule
`default_nettype wire

[sv/vsvb_fold.sv]
`default_nettype none
module vsvb_fold #(
  parameter int unsigned CoordWidth = vsvb_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire vsvb_pkg::vtx_flags_t in_flags_i,
  input  wire logic [vsvb_pkg::NUM_ROWS-1:0][CoordWidth-1:0] in_coord_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output vsvb_pkg::bounds_req_t     out_req_o
);
  import vsvb_pkg::*;

  logic signed [DATA_W-1:0] min_q [NUM_ROWS];
  logic signed [DATA_W-1:0] max_q [NUM_ROWS];
  logic signed [DATA_W-1:0] min_d [NUM_ROWS];
  logic signed [DATA_W-1:0] max_d [NUM_ROWS];
  logic        out_vld_q;
  bounds_req_t out_q;
  logic        out_free;
  logic        fire;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_ready_o = !in_flags_i.last || out_free;
  assign fire       = in_valid_i && in_ready_o;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    logic signed [DATA_W-1:0] crd;
    logic signed [DATA_W-1:0] base_min;
    logic signed [DATA_W-1:0] base_max;
    assign crd      = DATA_W'(signed'(in_coord_i[r]));
    assign base_min = in_flags_i.first ? '0 : min_q[r];
    assign base_max = in_flags_i.first ? '0 : max_q[r];
    assign min_d[r] = (crd < base_min) ? crd : base_min;
    assign max_d[r] = (crd > base_max) ? crd : base_max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        min_q[r] <= '0;
        max_q[r] <= '0;
      end
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          min_q[r] <= min_d[r];
          max_q[r] <= max_d[r];
        end
      end
      if (fire && in_flags_i.last) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_flags_i.last) begin
      out_q.min_x <= min_d[0];
      out_q.max_x <= max_d[0];
      out_q.min_y <= min_d[1];
      out_q.max_y <= max_d[1];
      out_q.min_z <= min_d[2];
      out_q.max_z <= max_d[2];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

endmodule
`default_nettype wire

[sv/view_space_vertex_bounds_top.sv]
// Throughput: one vertex per cycle while in_stall_o is low; the twelve products of a vertex are formed in one stage.
// Stages: input register, product register, sum register, clamped coordinate register,
// bounds fold with output register.
// Reset: pipeline empty, bounds zero, matrix registers back to the identity rows.
`default_nettype none
module view_space_vertex_bounds_top #(
  parameter int unsigned COORD_WIDTH   = vsvb_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = vsvb_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire vsvb_pkg::vertex_req_t       in_req_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output vsvb_pkg::bounds_req_t            out_req_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vsvb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [vsvb_pkg::CFG_W-1:0]  pwdata,
  output logic      [vsvb_pkg::CFG_W-1:0]  prdata,
  output logic                             pready
);
  import vsvb_pkg::*;

  cfg_regs_t  cfg;
  logic       mul_ready;
  logic       mul_valid;
  vtx_flags_t mul_flags;
  logic [NUM_ROWS-1:0][NUM_COLS-1:0][2*COORD_WIDTH-1:0] mul_prod;
  logic       red_ready;
  logic       red_valid;
  vtx_flags_t red_flags;
  logic [NUM_ROWS-1:0][COORD_WIDTH-1:0] red_coord;
  logic       fold_ready;

  assign in_stall_o = !mul_ready;

  vsvb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vsvb_mult #(
    .CoordWidth (COORD_WIDTH)
  ) u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (mul_ready),
    .in_req_i    (in_req_i),
    .cfg_i       (cfg),
    .out_valid_o (mul_valid),
    .out_ready_i (red_ready),
    .out_flags_o (mul_flags),
    .out_prod_o  (mul_prod)
  );

  vsvb_reduce #(
    .CoordWidth   (COORD_WIDTH),
    .FractionBits (FRACTION_BITS)
  ) u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (red_ready),
    .in_flags_i  (mul_flags),
    .in_prod_i   (mul_prod),
    .out_valid_o (red_valid),
    .out_ready_i (fold_ready),
    .out_flags_o (red_flags),
    .out_coord_o (red_coord)
  );

  vsvb_fold #(
    .CoordWidth (COORD_WIDTH)
  ) u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (red_valid),
    .in_ready_o  (fold_ready),
    .in_flags_i  (red_flags),
    .in_coord_i  (red_coord),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
`default_nettype wire

[test/view_space_vertex_bounds_top_tb.sv]
`timescale 1ns / 1ps
module view_space_vertex_bounds_top_tb;
  import vsvb_pkg::*;

  localparam int unsigned FRAC = FRACTION_BITS_DEF;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_VERTICES = 163;
  localparam logic signed [95:0] SAT_HI = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] SAT_LO = -96'sh8000_0000;

  typedef enum int {COEF_SMALL, COEF_FULL, COEF_EXTREME} coef_kind_e;
  typedef enum int {BATCH_WELL, BATCH_NO_FIRST, BATCH_NO_LAST, BATCH_NOISE} batch_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  vertex_req_t in_req = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  bounds_req_t out_req_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;

  vertex_req_t pending_vertices[$];
  bounds_req_t expected_bounds[$];
  logic [CFG_W-1:0] matrix_regs [NUM_REGS];
  int bound_lo [NUM_ROWS];
  int bound_hi [NUM_ROWS];
  string field_names [6] = '{"min_x", "max_x", "min_y", "max_y", "min_z", "max_z"};

  bit in_fire = 1'b0;
  bit calm_phase = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int unsigned cycle_count = 0;
  int errors = 0;
  int vertices_taken = 0;
  int bounds_checked = 0;
  int cfg_writes = 0;
  int matrix_settings = 1;

  view_space_vertex_bounds_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_req_o  (out_req_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0001_0000;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom;
    if (r == 3) return extreme_value();
    return 32'($urandom_range(0, 32'h8_0000) - 32'h4_0000);
  endfunction

  function automatic logic [31:0] pick_coef(coef_kind_e kind);
    logic [31:0] small_val;
    small_val = 32'($urandom_range(0, 32'h4_0000) - 32'h2_0000);
    case (kind)
      COEF_FULL: return $urandom;
      COEF_EXTREME: return ($urandom_range(0, 1) != 0) ? extreme_value() : small_val;
      default: return small_val;
    endcase
  endfunction

  // One view-space coordinate: exact sum of four products, floored, saturated.
  function automatic int view_coord(int row, vertex_req_t v);
    logic signed [95:0] acc;
    logic signed [95:0] shifted;
    logic [CFG_W-1:0] r;
    int comp [4];
    int coeff;
    longint prod;
    comp = '{v.vertex_x, v.vertex_y, v.vertex_z, v.vertex_w};
    acc = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      r = matrix_regs[row * 2 + c / 2];
      coeff = (c % 2 != 0) ? r[63:32] : r[31:0];
      prod = longint'(coeff) * longint'(comp[c]);
      acc = acc + prod;
    end
    shifted = acc >>> FRAC;
    if (shifted > SAT_HI) return 32'h7FFF_FFFF;
    if (shifted < SAT_LO) return 32'h8000_0000;
    return shifted[31:0];
  endfunction

  function automatic void fold_vertex(vertex_req_t v);
    bounds_req_t b;
    int p;
    if (v.first_vertex) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        bound_lo[r] = 0;
        bound_hi[r] = 0;
      end
    end
    for (int r = 0; r < NUM_ROWS; r++) begin
      p = view_coord(r, v);
      if (p < bound_lo[r]) bound_lo[r] = p;
      if (p > bound_hi[r]) bound_hi[r] = p;
    end
    if (v.last_vertex) begin
      b.min_x = bound_lo[0];
      b.max_x = bound_hi[0];
      b.min_y = bound_lo[1];
      b.max_y = bound_hi[1];
      b.min_z = bound_lo[2];
      b.max_z = bound_hi[2];
      expected_bounds.push_back(b);
    end
  endfunction

  function automatic void check_bounds(bounds_req_t got);
    bounds_req_t want;
    logic [5:0][31:0] want_f;
    logic [5:0][31:0] got_f;
    if (expected_bounds.size() == 0) begin
      errors++;
      $display("%0t: unexpected bounds result %h", $time, got);
      return;
    end
    want = expected_bounds.pop_front();
    want_f = want;
    got_f = got;
    for (int i = 5; i >= 0; i--) begin
      if (want_f[i] !== got_f[i]) begin
        errors++;
        $display("%0t: %s expected %0d (%h) got %0d (%h)", $time, field_names[5 - i],
                 $signed(want_f[i]), want_f[i], $signed(got_f[i]), got_f[i]);
      end
    end
    bounds_checked++;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_vertices.size() != 0) begin
        in_req <= pending_vertices.pop_front();
        in_valid <= 1'b1;
        send_gap <= calm_phase ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= calm_phase ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall_o;
    if (rst_n) begin
      if (in_valid && !in_stall_o) begin
        fold_vertex(in_req);
        vertices_taken++;
      end
      if (out_valid_o && !out_stall) check_bounds(out_req_o);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d vertices and %0d results outstanding", $time,
               pending_vertices.size(), expected_bounds.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cfg_write(int unsigned idx, logic [CFG_W-1:0] val);
    logic [CFG_W-1:0] readback;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 8);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < NUM_REGS) begin
      matrix_regs[idx] = val;
      cfg_writes++;
      @(negedge clk);
      psel <= 1'b1;
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      readback = prdata;
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
      if (readback !== val) begin
        errors++;
        $display("%0t: register %0d readback expected %h got %h", $time, idx, val, readback);
      end
    end
  endtask

  task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w,
                            logic first, logic last);
    vertex_req_t v;
    v = '{x, y, z, w, first, last};
    pending_vertices.push_back(v);
  endtask

  task automatic queue_random_phase(int count);
    batch_kind_e kind;
    int n;
    int len;
    logic first;
    logic last;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      case ($urandom_range(0, 9))
        0: kind = BATCH_NOISE;
        1: kind = BATCH_NO_FIRST;
        2: kind = BATCH_NO_LAST;
        default: kind = BATCH_WELL;
      endcase
      for (int i = 0; i < len; i++) begin
        first = (kind == BATCH_NOISE) ? 1'($urandom) : (kind != BATCH_NO_FIRST && i == 0);
        last = (kind == BATCH_NOISE) ? 1'($urandom) : (kind != BATCH_NO_LAST && i == len - 1);
        add_vertex(rand_coord(), rand_coord(), rand_coord(),
                   ($urandom_range(0, 1) != 0) ? 32'h0001_0000 : rand_coord(), first, last);
      end
      n += len;
    end
  endtask

  // Hold until every request is taken and every result has arrived.
  task automatic wait_drained();
    while (pending_vertices.size() != 0 || in_valid || expected_bounds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] val;
    for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = cfg_reset_value(IDX_W'(i));
    for (int r = 0; r < NUM_ROWS; r++) begin
      bound_lo[r] = 0;
      bound_hi[r] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 1'b0, 1'b0);
    add_vertex(32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000, 32'h0001_0000, 1'b0, 1'b1);
    add_vertex(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 1'b0, 1'b1);
    add_vertex(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0001_0000, 1'b1, 1'b1);
    add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b0);
    add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    add_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
    add_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
    add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    wait_drained();

    cfg_write(REG_ROW_X_COLS01, 64'h8000_0000_7FFF_FFFF);
    cfg_write(REG_ROW_X_COLS23, 64'h7FFF_FFFF_7FFF_FFFF);
    cfg_write(REG_ROW_Y_COLS01, 64'h8000_0000_8000_0000);
    cfg_write(REG_ROW_Y_COLS23, 64'h8000_0000_8000_0000);
    cfg_write(REG_ROW_Z_COLS01, 64'hFFFF_0000_0001_0000);
    cfg_write(REG_ROW_Z_COLS23, 64'h0000_0000_7FFF_FFFF);
    cfg_write(NUM_REGS, {$urandom, $urandom});
    cfg_write(NUM_REGS + 1, {$urandom, $urandom});
    matrix_settings++;
    add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
    add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
    add_vertex(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
    add_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0);
    add_vertex(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0, 1'b1);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm_phase = (p % 4 == 2);
      for (int i = 0; i < NUM_REGS; i++) begin
        if (p == 3) val = '0;
        else if (p == 6) val = '1;
        else val = {pick_coef(coef_kind_e'(p % 3)), pick_coef(coef_kind_e'(p % 3))};
        cfg_write(i, val);
      end
      matrix_settings++;
      queue_random_phase(PHASE_VERTICES);
      wait_drained();
    end

    $display("Covered %0d vertices over %0d matrix settings with %0d register writes;",
             vertices_taken, matrix_settings, cfg_writes);
    $display("%0d bounds results checked, %0d mismatches.", bounds_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
